FILE: src/pacu_pkg.sv
// ----------------------------------------------------------------------------
// Park angle coefficient unit: shared constants and types
// Register indexes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package pacu_pkg;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_OMEGA  = 2'd1,
    REG_ANGLE  = 2'd2,
    REG_STEP   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ANGLE,
    ST_CORDIC,
    ST_STORE,
    ST_OUT
  } state_t;

  localparam logic [29:0] TurnPerRad   = 30'd683565276;
  localparam logic [31:0] ThirdTurn    = 32'd1431655765;
  localparam logic [31:0] StepReset    = 32'd214748;
  localparam int          CordicN      = 24;
  localparam logic signed [33:0] CordicX0 = 34'sd532382612;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: src/park_angle_coefficient_unit.sv
// ----------------------------------------------------------------------------
// Park angle coefficient unit
// Advances the Park angle once per time step and gives the six dq coefficients.
// ----------------------------------------------------------------------------
// Usage: an input transaction (step_time, measured_omega) on in_valid/in_ready
// starts one step; one result transaction (angle and six coefficients) leaves
// on out_valid/out_ready. The speed product is formed bit-serially by a
// shift-and-add multiplier (one bit of the multiplier operand per cycle),
// the angle is added next, then one shared CORDIC unit runs 24 iterations
// for each of the three phase angles. One step is in flight at a time; the
// next is taken once the result register is loaded into the output stage.
// The result is held in an output register while the receiver stalls; a new
// transaction may enter and will wait for the output register to free
// before its result is written.
// Reset (rst, synchronous) restores the registers to their documented
// values: constant speed mode, zero omegas, zero angle, default step length.
// Configuration writes are taken on cfg_we at any time and are meant for
// idle periods only.
// ----------------------------------------------------------------------------
module park_angle_coefficient_unit #(
  parameter int ANGLE_BITS = 32,
  parameter int COEF_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [47:0]                 step_time,
  input  logic signed [31:0]          measured_omega,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 angle,
  output logic signed [COEF_BITS-1:0] coef_a_d,
  output logic signed [COEF_BITS-1:0] coef_a_q,
  output logic signed [COEF_BITS-1:0] coef_b_d,
  output logic signed [COEF_BITS-1:0] coef_b_q,
  output logic signed [COEF_BITS-1:0] coef_c_d,
  output logic signed [COEF_BITS-1:0] coef_c_q
);
  import pacu_pkg::*;

  localparam int ProdW  = 112;  // signed speed of up to 64 bits times 48-bit operand
  localparam int ShCon  = 76 - ANGLE_BITS;
  localparam int ShVar  = 81 - ANGLE_BITS;
  localparam int AngSh  = ANGLE_BITS - 32;

  // Configuration and state
  logic                  mode;
  logic [31:0]           start_omega_r, start_angle_r, step_length_r;
  logic [ANGLE_BITS-1:0] running_angle;
  logic signed [31:0]    cur_omega, prev_omega;

  function automatic logic [ANGLE_BITS-1:0] start_to_angle(input logic [31:0] a);
    logic [ANGLE_BITS+31:0] w;
    begin
      w = {{ANGLE_BITS{1'b0}}, a} << ANGLE_BITS;
      return w[ANGLE_BITS+31:32];
    end
  endfunction

  // Step control
  state_t state, state_next;
  logic [5:0]  mcnt;
  logic [1:0]  phase;
  logic [4:0]  it;
  logic        is_const;
  logic [47:0] mplier;
  logic signed [ProdW-1:0] mcand, prod;
  logic signed [31:0] meas_hold;
  logic [31:0] a32;

  // CORDIC datapath
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [1:0]  quad;
  logic signed [COEF_BITS-1:0] rd [6];

  // Output stage
  logic obusy;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL;
      ST_MUL:    if (mcnt == 6'd47) state_next = ST_ANGLE;
      ST_ANGLE:  state_next = ST_CORDIC;
      ST_CORDIC: if (it == 5'd23 && phase == 2'd2) state_next = ST_STORE;
      ST_STORE:  state_next = ST_OUT;
      ST_OUT:    if (!obusy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Rounded product slice and angle conversions
  logic [ProdW-1:0] prod_rnd;
  logic [ANGLE_BITS-1:0] delta, new_angle;
  logic [31:0] ang32;
  logic [ANGLE_BITS:0] ang_rnd;
  always_comb begin
    if (is_const) begin
      prod_rnd = prod + (ProdW'(1) << (ShCon - 1));
      delta = ANGLE_BITS'(prod_rnd >> ShCon);
      new_angle = start_to_angle(start_angle_r) + delta;
    end else begin
      prod_rnd = prod + (ProdW'(1) << (ShVar - 1));
      delta = ANGLE_BITS'(prod_rnd >> ShVar);
      new_angle = running_angle + delta;
    end
    if (AngSh > 0) begin
      ang_rnd = {1'b0, new_angle} + ((ANGLE_BITS+1)'(1) << (AngSh > 0 ? AngSh - 1 : 0));
      ang32 = 32'(ang_rnd >> (AngSh > 0 ? AngSh : 0));
    end else begin
      ang_rnd = {1'b0, new_angle};
      ang32 = 32'({ang_rnd, 32'b0} >> ANGLE_BITS);
    end
  end

  // Phase angle and quadrant reduction
  logic [31:0] pang, pred;
  logic [1:0]  pquad;
  always_comb begin
    case (phase)
      2'd0:    pang = a32;
      2'd1:    pang = a32 - ThirdTurn;
      default: pang = a32 + ThirdTurn;
    endcase
    pquad = 2'((pang + 32'h20000000) >> 30);
    pred  = pang - {pquad, 30'b0};
  end

  // One CORDIC iteration
  logic signed [33:0] nx, ny, ysh, xsh;
  logic signed [32:0] nz, at;
  always_comb begin
    ysh = cy >>> it;
    xsh = cx >>> it;
    at  = $signed({1'b0, atan_turn(it)});
    if (!cz[32]) begin
      nx = cx - ysh; ny = cy + xsh; nz = cz - at;
    end else begin
      nx = cx + ysh; ny = cy - xsh; nz = cz + at;
    end
  end

  // Final rotation and rounding
  logic signed [34:0] cc, ss;
  logic signed [COEF_BITS-1:0] dq_d, dq_q;
  function automatic logic signed [COEF_BITS-1:0] coef_out(input logic signed [34:0] v);
    logic signed [34:0] c;
    begin
      c = (v + (35'sd1 <<< (30 - COEF_BITS))) >>> (31 - COEF_BITS);
      if (c > 35'((1 << (COEF_BITS - 1)) - 1)) return {1'b0, {(COEF_BITS-1){1'b1}}};
      if (c < -35'(1 << (COEF_BITS - 1))) return {1'b1, {(COEF_BITS-1){1'b0}}};
      return c[COEF_BITS-1:0];
    end
  endfunction
  always_comb begin
    case (quad)
      2'd0:    begin cc = 35'(nx);  ss = 35'(ny);  end
      2'd1:    begin cc = -35'(ny); ss = 35'(nx);  end
      2'd2:    begin cc = -35'(nx); ss = -35'(ny); end
      default: begin cc = 35'(ny);  ss = -35'(nx); end
    endcase
    dq_d = coef_out(-cc);
    dq_q = coef_out(ss);
  end

  // Datapath registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
      start_omega_r <= '0;
      start_angle_r <= '0;
      step_length_r <= StepReset;
      running_angle <= '0;
      cur_omega <= '0;
      prev_omega <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:  mode <= cfg_data[0];
          REG_OMEGA: begin
            start_omega_r <= cfg_data;
            cur_omega <= cfg_data;
            prev_omega <= cfg_data;
          end
          REG_ANGLE: begin
            start_angle_r <= cfg_data;
            running_angle <= start_to_angle(cfg_data);
          end
          REG_STEP:  step_length_r <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_ANGLE) running_angle <= new_angle;
      if (state == ST_STORE && !is_const) begin
        prev_omega <= cur_omega;
        cur_omega <= meas_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // Latch the transaction and set up the serial multiplier
        is_const  <= mode;
        meas_hold <= measured_omega;
        mcnt <= '0;
        prod <= '0;
        if (mode) begin
          mcand  <= ProdW'($signed(cur_omega) * $signed({1'b0, TurnPerRad}));
          mplier <= step_time;
        end else begin
          mcand  <= ProdW'(($signed({cur_omega[31], cur_omega}) +
                            $signed({prev_omega[31], prev_omega})) *
                           $signed({1'b0, TurnPerRad}));
          mplier <= {16'b0, step_length_r};
        end
      end
      ST_MUL: begin
        // One multiplier bit per cycle
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        mcnt   <= mcnt + 6'd1;
      end
      ST_ANGLE: begin
        a32 <= ang32;
        phase <= 2'd0;
        it <= '0;
        cx <= CordicX0; cy <= '0;
      end
      ST_CORDIC: begin
        if (it == 5'd0) begin
          // Load phase angle into the rotator, iteration zero folded in
          quad <= pquad;
          it <= 5'd1;
          cz <= $signed({pred[31], pred}) + (pred[31] ? 33'sh20000000 : -33'sh20000000);
          cx <= CordicX0;
          cy <= pred[31] ? -CordicX0 : CordicX0;
        end else begin
          cx <= nx; cy <= ny; cz <= nz;
          if (it == 5'd23) begin
            rd[{phase, 1'b0}] <= dq_d;
            rd[{phase, 1'b1}] <= dq_q;
            phase <= phase + 2'd1;
            it <= '0;
          end else begin
            it <= it + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      obusy <= 1'b0;
    end else begin
      if (obusy && out_ready) obusy <= 1'b0;
      if (state == ST_OUT && !obusy) begin
        obusy <= 1'b1;
        angle <= a32;
        coef_a_d <= rd[0]; coef_a_q <= rd[1];
        coef_b_d <= rd[2]; coef_b_q <= rd[3];
        coef_c_d <= rd[4]; coef_c_q <= rd[5];
      end
    end
  end
  assign out_valid = obusy;

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(angle))
    else $error("result dropped");
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ANGLE) |-> (mcnt == 6'd48)) else $error("multiplier count");
endmodule

FILE: verif/pacu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Park angle coefficient checker
// Watches the configuration port and both channels, predicts each step's angle
// and six coefficients, and compares them against what the block returns.
// ----------------------------------------------------------------------------
module pacu_checker #(
  parameter int COEF_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [47:0]          step_time,
  input  logic [31:0]          measured_omega,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [31:0]          angle,
  input  logic [COEF_BITS-1:0] coef_a_d,
  input  logic [COEF_BITS-1:0] coef_a_q,
  input  logic [COEF_BITS-1:0] coef_b_d,
  input  logic [COEF_BITS-1:0] coef_b_q,
  input  logic [COEF_BITS-1:0] coef_c_d,
  input  logic [COEF_BITS-1:0] coef_c_q,
  output int                   fail_count,
  output int                   pending
);
  import pacu_pkg::*;

  typedef struct packed {
    logic [31:0]          ang;
    logic [COEF_BITS-1:0] ad, aq, bd, bq, cd, cq;
  } park_result_t;

  park_result_t expected_steps[$];

  logic        const_mode;
  logic [31:0] init_angle, dt_len, run_angle;
  logic signed [31:0] omega_now, omega_prev;

  // Round an internal 2^30-scaled value to the coefficient width, saturating.
  function automatic logic [COEF_BITS-1:0] to_coef(input longint v);
    longint c;
    longint hi;
    longint lo;
    c  = (v + (longint'(1) <<< (30 - COEF_BITS))) >>> (31 - COEF_BITS);
    hi = (longint'(1) <<< (COEF_BITS - 1)) - 1;
    lo = -(longint'(1) <<< (COEF_BITS - 1));
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    return c[COEF_BITS-1:0];
  endfunction

  // Rotate the scaled start vector to the angle; give -cos and +sin terms.
  task automatic rotate_phase(input logic [31:0] a, output logic [COEF_BITS-1:0] d,
                              output logic [COEF_BITS-1:0] q);
    logic [1:0]  quad;
    logic [31:0] rem;
    longint x, y, z, nx, c, s;
    quad = 2'((a + 32'h20000000) >> 30);
    rem  = a - {quad, 30'd0};
    z = longint'(signed'(rem));
    x = CordicX0;
    y = 0;
    for (int i = 0; i < CordicN; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_turn(5'(i)));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_turn(5'(i)));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    d = to_coef(-c);
    q = to_coef(s);
  endtask

  // Advance the angle for one step and build the expected result.
  task automatic predict_step(input logic [47:0] t, input logic [31:0] meas);
    logic signed [127:0] prod;
    logic signed [127:0] w;
    park_result_t r;
    if (const_mode) begin
      w    = 128'(longint'(omega_now) * longint'(TurnPerRad));
      prod = w * $signed({80'd0, t}) + (128'sd1 <<< 43);
      run_angle = init_angle + prod[75:44];
    end else begin
      w    = 128'((longint'(omega_now) + longint'(omega_prev)) * longint'(TurnPerRad));
      prod = w * $signed({96'd0, dt_len}) + (128'sd1 <<< 48);
      run_angle = run_angle + prod[80:49];
    end
    r.ang = run_angle;
    rotate_phase(run_angle, r.ad, r.aq);
    rotate_phase(run_angle - ThirdTurn, r.bd, r.bq);
    rotate_phase(run_angle + ThirdTurn, r.cd, r.cq);
    expected_steps = {expected_steps, r};
    if (!const_mode) begin
      omega_prev = omega_now;
      omega_now  = meas;
    end
  endtask

  assign pending = expected_steps.size();

  // Track registers, predict on input transactions, compare on output ones.
  always @(posedge clk) begin
    park_result_t got, want;
    if (rst) begin
      const_mode <= 1'b1;
      init_angle <= '0;
      dt_len     <= StepReset;
      run_angle  <= '0;
      omega_now  <= '0;
      omega_prev <= '0;
      fail_count <= 0;
      expected_steps.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:  const_mode <= cfg_data[0];
          REG_OMEGA: begin omega_now <= cfg_data; omega_prev <= cfg_data; end
          REG_ANGLE: begin init_angle <= cfg_data; run_angle <= cfg_data; end
          REG_STEP:  dt_len <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_step(step_time, measured_omega);
      if (out_valid && out_ready) begin
        got = '{angle, coef_a_d, coef_a_q, coef_b_d, coef_b_q, coef_c_d, coef_c_q};
        if (expected_steps.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("chk: unexpected result angle=%h", angle);
        end else begin
          want = expected_steps.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("chk: mismatch exp=%h got=%h", want, got);
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Park angle coefficient unit testbench
// Drives register settings and time steps with random gaps and stalls; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pacu_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [47:0] step_time = '0;
  logic signed [31:0] measured_omega = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] angle;
  logic signed [15:0] coef_a_d, coef_a_q, coef_b_d, coef_b_q, coef_c_d, coef_c_q;
  int fail_count, pending, idle_cycles, step_count;

  always #6 clk = ~clk;

  park_angle_coefficient_unit DUT (.*);

  pacu_checker u_checker (.*);

  // Stall the receiver on its own pattern: long open stretches and busy ones.
  always @(posedge clk) begin
    int mode_ctr;
    mode_ctr = (step_count / 64) % 3;
    if (mode_ctr == 0) out_ready <= 1'b1;
    else if (mode_ctr == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 4) == 0);
  end

  // Count cycles with no transaction and end the run when it runs too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_step(input logic [47:0] t, input logic [31:0] w);
    in_valid       <= 1'b1;
    step_time      <= t;
    measured_omega <= w;
    do @(posedge clk); while (!in_ready);
    step_count++;
  endtask

  // Let the last accepted step be counted first, then wait until all are out.
  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random step: mostly small realistic times, sometimes full-range values.
  task automatic random_burst(input int n);
    logic [47:0] t;
    logic [31:0] w;
    int burst;
    for (int k = 0; k < n; k++) begin
      t = {$urandom(), $urandom()};
      if ($urandom_range(0, 3) != 0) t = t & 48'h000_3FFF_FFFF;
      w = $urandom();
      if ($urandom_range(0, 2) == 0) w = $signed(w) >>> $urandom_range(0, 16);
      send_step(t, w);
      burst = $urandom_range(0, 7);
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    step_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, negative speeds.
    send_step(48'd0, 32'd0);
    send_step(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_OMEGA, 32'h8000_0000);
    write_reg(REG_ANGLE, 32'hFFFF_FFFF);
    send_step(48'hFFFF_FFFF_FFFF, 32'h8000_0000);
    send_step(48'h0000_1000_0000, 32'd0);
    send_step(48'h0000_0000_0001, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_MODE, 1'b0);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_OMEGA, 32'h7FFF_FFFF);
    send_step(48'd5, 32'h8000_0000);
    send_step(48'd6, 32'h7FFF_FFFF);
    send_step(48'd7, 32'h0001_0000);
    send_step(48'd8, 32'hFFFF_0000);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_STEP, 32'd0);
    write_reg(REG_ANGLE, 32'h4000_0000);
    send_step(48'd9, 32'h0010_0000);
    send_step(48'd9, 32'h0010_0000);
    in_valid <= 1'b0;
    drain();

    // Random phases under different settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, ph[0]);
      write_reg(REG_STEP, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h00FF_FFFF));
      write_reg(REG_OMEGA, $urandom());
      write_reg(REG_ANGLE, $urandom());
      random_burst(90);
      drain();
    end

    $display("tb: %0d steps sent over both speed modes and eight register settings",
             step_count);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
src/pacu_pkg.sv
src/park_angle_coefficient_unit.sv
verif/pacu_checker.sv
verif/tb_top.sv
